@@ sv/srsm_pkg.sv @@
// Shared types, constants and helpers for the sensor rate/stuck monitor.
// No dependencies; used by every srsm_* module and the top level.
`default_nettype none

package srsm_pkg;

  localparam int unsigned CHANNELS   = 8;
  localparam int unsigned CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CHAN_W     = 3;
  localparam int unsigned TEMP_W     = 16;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned SCAN_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [STEP_W-1:0] MAX_STEP_RST    = STEP_W'(50);
  localparam logic [STEP_W-1:0] MIN_CHANGE_RST  = STEP_W'(5);
  localparam logic [SCAN_W-1:0] STUCK_SCANS_RST = SCAN_W'(60);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_STEP    = 2'd0,
    CFG_MIN_CHANGE  = 2'd1,
    CFG_STUCK_SCANS = 2'd2
  } cfg_reg_e;

  // per-channel history
  typedef struct packed {
    logic              primed;
    logic [TEMP_W-1:0] prev;
    logic [TEMP_W-1:0] refv;
    logic [SCAN_W-1:0] count;
  } chan_t;

  typedef struct packed {
    logic [STEP_W-1:0] max_step;
    logic [STEP_W-1:0] min_change;
    logic [SCAN_W-1:0] stuck_scans;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic rate;
    logic stuck;
  } verdict_t;

  typedef struct packed {
    logic                wr_en;
    logic [CH_IDX_W-1:0] idx;
    chan_t               data;
  } chan_wr_t;

  // |a - b| of two signed readings, exact over the full range
  function automatic logic [TEMP_W:0] abs_diff(logic [TEMP_W-1:0] a, logic [TEMP_W-1:0] b);
    logic signed [TEMP_W:0] d;
    d = $signed({a[TEMP_W-1], a}) - $signed({b[TEMP_W-1], b});
    return d[TEMP_W] ? unsigned'(-d) : unsigned'(d);
  endfunction

endpackage

`default_nettype wire

@@ sv/srsm_chan_store.sv @@
// Per-channel history registers: one read port, one write port, clear-all.
// Depends on srsm_pkg.
`default_nettype none

module srsm_chan_store (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         clear_i,
  input  wire srsm_pkg::chan_wr_t           wr_i,
  input  wire logic [srsm_pkg::CH_IDX_W-1:0] rd_idx_i,
  output srsm_pkg::chan_t                   rd_data_o
);

  srsm_pkg::chan_t hist_q [srsm_pkg::CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(srsm_pkg::CHANNELS); i++) begin
        hist_q[i] <= '0;
      end
    end else if (clear_i) begin
      for (int i = 0; i < int'(srsm_pkg::CHANNELS); i++) begin
        hist_q[i] <= '0;
      end
    end else if (wr_i.wr_en) begin
      hist_q[wr_i.idx] <= wr_i.data;
    end
  end

  assign rd_data_o = hist_q[rd_idx_i];

endmodule

`default_nettype wire

@@ sv/srsm_judge.sv @@
// Judges one sample against its channel history and builds the new history.
// Purely combinational; depends on srsm_pkg.
`default_nettype none

module srsm_judge (
  input  wire logic                           in_range_i,
  input  wire logic                           sample_valid_i,
  input  wire logic [srsm_pkg::TEMP_W-1:0]    temp_i,
  input  wire srsm_pkg::chan_t                cur_i,
  input  wire srsm_pkg::cfg_t                 cfg_i,
  output srsm_pkg::chan_t                     nxt_o,
  output logic                                wr_en_o,
  output srsm_pkg::verdict_t                  verdict_o
);

  logic [srsm_pkg::TEMP_W:0]   step_dist;
  logic [srsm_pkg::TEMP_W:0]   ref_dist;
  logic [srsm_pkg::SCAN_W-1:0] cnt_inc;

  assign step_dist = srsm_pkg::abs_diff(temp_i, cur_i.prev);
  assign ref_dist  = srsm_pkg::abs_diff(temp_i, cur_i.refv);
  // saturates at stuck_scans
  assign cnt_inc   = (cur_i.count < cfg_i.stuck_scans) ?
                     cur_i.count + srsm_pkg::SCAN_W'(1) : cur_i.count;

  always_comb begin
    nxt_o           = cur_i;
    wr_en_o         = 1'b0;
    verdict_o.valid = sample_valid_i;
    verdict_o.rate  = 1'b0;
    verdict_o.stuck = 1'b0;
    if (in_range_i) begin
      wr_en_o = 1'b1;
      if (!sample_valid_i) begin
        nxt_o = '0;
      end else if (!cur_i.primed) begin
        nxt_o.primed = 1'b1;
        nxt_o.prev   = temp_i;
        nxt_o.refv   = temp_i;
        nxt_o.count  = '0;
      end else if (step_dist > {1'b0, cfg_i.max_step}) begin
        nxt_o           = '0;
        verdict_o.rate  = 1'b1;
        verdict_o.valid = 1'b0;
      end else begin
        nxt_o.prev = temp_i;
        if (ref_dist >= {1'b0, cfg_i.min_change}) begin
          nxt_o.refv  = temp_i;
          nxt_o.count = '0;
        end else begin
          nxt_o.count = cnt_inc;
          if (cnt_inc >= cfg_i.stuck_scans) begin
            verdict_o.stuck = 1'b1;
            verdict_o.valid = 1'b0;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/sensor_rate_stuck_monitor_top.sv @@
// Top level of the sensor rate-of-change / stuck plausibility monitor.
// Depends on srsm_pkg, srsm_chan_store and srsm_judge.
`default_nettype none

// Channel   Handshake                 Payload
// -------   ------------------------  -----------------------------------------------
// in        in_valid_i / in_ready_o   operation_i, channel_i, temperature_i,
//                                     sample_valid_i
// out       out_valid_o / out_ready_i channel_out_o, valid_out_o, rate_fault_o,
//                                     stuck_fault_o
// cfg       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i (0 max_step,
//                                     1 min_change, 2 stuck_scans)
//
// One transaction per cycle sustained while results are taken. A sample passes
// the input register, then the judge and history update into the result
// register. A clear command gives no result. History lives in flip-flops
// cleared by reset, so the block is ready right out of reset. When the result
// register is full and not taken, the input register holds its item and
// in_ready_o drops; a clear command still passes since it needs no result slot.

module sensor_rate_stuck_monitor_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,

  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              operation_i,
  input  wire logic [srsm_pkg::CHAN_W-1:0]       channel_i,
  input  wire logic signed [srsm_pkg::TEMP_W-1:0] temperature_i,
  input  wire logic                              sample_valid_i,

  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [srsm_pkg::CHAN_W-1:0]            channel_out_o,
  output logic                                   valid_out_o,
  output logic                                   rate_fault_o,
  output logic                                   stuck_fault_o,

  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [srsm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [srsm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned IdxW = srsm_pkg::CH_IDX_W;

  // ---------------- configuration registers ----------------
  srsm_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (srsm_pkg::cfg_reg_e'(cfg_index_i))
        srsm_pkg::CFG_MAX_STEP:    cfg_d.max_step    = cfg_data_i;
        srsm_pkg::CFG_MIN_CHANGE:  cfg_d.min_change  = cfg_data_i;
        srsm_pkg::CFG_STUCK_SCANS: cfg_d.stuck_scans = cfg_data_i[srsm_pkg::SCAN_W-1:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_step    <= srsm_pkg::MAX_STEP_RST;
      cfg_q.min_change  <= srsm_pkg::MIN_CHANGE_RST;
      cfg_q.stuck_scans <= srsm_pkg::STUCK_SCANS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------- input register ----------------
  logic                          in_v_q, in_v_d;
  srsm_pkg::op_e                 op_q;
  logic [srsm_pkg::CHAN_W-1:0]   ch_q;
  logic [srsm_pkg::TEMP_W-1:0]   temp_q;
  logic                          sv_q;

  logic in_fire, advance, out_free, do_sample, do_clear;

  assign out_free   = !out_valid_o || out_ready_i;
  // a clear needs no result slot
  assign advance    = in_v_q && (out_free || (op_q == srsm_pkg::OP_CLEAR));
  assign in_ready_o = !in_v_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;
  assign do_sample  = advance && (op_q == srsm_pkg::OP_SAMPLE);
  assign do_clear   = advance && (op_q == srsm_pkg::OP_CLEAR);

  always_comb begin
    in_v_d = in_v_q;
    if (in_fire) begin
      in_v_d = 1'b1;
    end else if (advance) begin
      in_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= srsm_pkg::op_e'(operation_i);
      ch_q   <= channel_i;
      temp_q <= temperature_i;
      sv_q   <= sample_valid_i;
    end
  end

  // ---------------- judge and history ----------------
  logic               in_range;
  logic [IdxW-1:0]    ch_idx;
  srsm_pkg::chan_t    cur_hist, nxt_hist;
  logic               judge_wr;
  srsm_pkg::verdict_t verdict;
  srsm_pkg::chan_wr_t hist_wr;

  assign in_range = (int'(ch_q) < int'(srsm_pkg::CHANNELS));
  assign ch_idx   = IdxW'(ch_q);

  srsm_chan_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (do_clear),
    .wr_i      (hist_wr),
    .rd_idx_i  (ch_idx),
    .rd_data_o (cur_hist)
  );

  srsm_judge u_judge (
    .in_range_i     (in_range),
    .sample_valid_i (sv_q),
    .temp_i         (temp_q),
    .cur_i          (cur_hist),
    .cfg_i          (cfg_q),
    .nxt_o          (nxt_hist),
    .wr_en_o        (judge_wr),
    .verdict_o      (verdict)
  );

  assign hist_wr.wr_en = do_sample && judge_wr;
  assign hist_wr.idx   = ch_idx;
  assign hist_wr.data  = nxt_hist;

  // ---------------- result register ----------------
  logic out_v_q, out_v_d;
  logic [srsm_pkg::CHAN_W-1:0] out_ch_q;
  srsm_pkg::verdict_t          out_verdict_q;

  always_comb begin
    out_v_d = out_v_q;
    if (do_sample) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_sample) begin
      out_ch_q      <= ch_q;
      out_verdict_q <= verdict;
    end
  end

  assign out_valid_o   = out_v_q;
  assign channel_out_o = out_ch_q;
  assign valid_out_o   = out_verdict_q.valid;
  assign rate_fault_o  = out_verdict_q.rate;
  assign stuck_fault_o = out_verdict_q.stuck;

endmodule

`default_nettype wire

@@ sv/srsm_checker.sv @@
// Port-level checker for sensor_rate_stuck_monitor_top, attached by bind.
// Depends on srsm_pkg for field widths.
`default_nettype none

module srsm_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_ready_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [srsm_pkg::CHAN_W-1:0]       channel_out_o,
  input wire logic                              valid_out_o,
  input wire logic                              rate_fault_o,
  input wire logic                              stuck_fault_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(channel_out_o)
      && $stable(valid_out_o) && $stable(rate_fault_o) && $stable(stuck_fault_o))
    else $error("result changed while stalled");

  // any fault invalidates the sample
  a_fault_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (rate_fault_o || stuck_fault_o) |-> !valid_out_o)
    else $error("faulted sample reported valid");

  // a rate fault clears history, so the same sample cannot also be stuck
  a_one_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(rate_fault_o && stuck_fault_o))
    else $error("rate and stuck fault together");

  // an empty result slot never back-pressures the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result slot");

endmodule

bind sensor_rate_stuck_monitor_top srsm_checker u_srsm_checker (.*);

`default_nettype wire
